// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the sequential list table.
// Depends on nothing; each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge while out of reset.
`define LST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication with the consequent in the next cycle.
`define LST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lst_pkg.sv
// Package of the sequential list table: capacity, widths, operation and status codes,
// and the control struct that the top level hands to every list cell. Depends on nothing.
`default_nettype none

package lst_pkg;

  // Number of list entries, held one per cell.
  localparam int CAPACITY = 64;
  // Width of a zero-based entry index.
  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  // Width of the entry count (0 .. CAPACITY).
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width used when positions and counts are compared; one spare bit for pos + 1.
  localparam int CMP_W = ((CNT_W > 7) ? CNT_W : 7) + 1;

  localparam int DATA_W = 32;

  // Operation codes.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_LOCATE = 3'd2;
  localparam logic [2:0] OP_SORTED = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_MISSING = 2'd3;

  // Per-cycle command broadcast to all cells.
  typedef struct packed {
    logic                     shift_up;    // open a slot at tgt_idx
    logic                     shift_down;  // close the slot at tgt_idx
    logic [IDX_W-1:0]         tgt_idx;
    logic signed [DATA_W-1:0] new_val;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/lst_if.sv
// Valid/ready channel interfaces of the sequential list table: the operation
// channel and the result channel. Depends on nothing.
`default_nettype none

interface lst_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [6:0]         position;
  logic signed [31:0] value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

interface lst_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [6:0]         found_position;
  logic signed [31:0] removed_value;
  logic [6:0]         list_length;

  modport source (output valid, output status, output found_position,
                  output removed_value, output list_length, input ready);
  modport sink (input valid, input status, input found_position,
                input removed_value, input list_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sequential_list_table_top.sv
// Top level of the sequential list table: a chain of entry cells, the operation
// decoder and the result register. Depends on lst_pkg, lst_if, lst_cell, assert_macros.svh.
//
// Usage:
//   in_ch carries one operation per beat (operation, position, value); out_ch
//   returns exactly one result beat per operation (status, found_position,
//   removed_value, list_length). Both are valid/ready channels.
// Sequencing:
//   An operation is taken in the idle state and executed in the execute state,
//   where every cell shifts in parallel and the compare flags of all cells are
//   priority encoded. The result is registered when the operation executes. No
//   new operation is taken until the current one has executed, since the
//   single-entry command register in front of the chain holds it.
// Stalls:
//   A waiting result does not block acceptance of the next operation; that one
//   holds in the execute state until the result register is free.
// Reset:
//   rst_n (synchronous, active low) empties the list and drops any pending
//   result. Entry contents are not cleared; only positions below the count
//   are ever read.
`default_nettype none
`include "assert_macros.svh"

module sequential_list_table_top (
  input  wire logic clk,
  input  wire logic rst_n,
  lst_in_if.sink    in_ch,
  lst_out_if.source out_ch
);

  localparam int CAP   = lst_pkg::CAPACITY;
  localparam int IDX_W = lst_pkg::IDX_W;
  localparam int CNT_W = lst_pkg::CNT_W;
  localparam int CMP_W = lst_pkg::CMP_W;
  localparam int DW    = lst_pkg::DATA_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       op_r;
  logic [6:0]       pos_r;
  logic signed [DW-1:0] val_r;

  logic out_valid_r;
  logic [1:0]       status_r, status_nxt;
  logic [6:0]       found_r, found_nxt;
  logic signed [DW-1:0] removed_r, removed_nxt;
  logic [6:0]       length_r;

  logic in_fire, exec_fire;
  lst_pkg::cell_ctrl_t ctrl;
  logic [IDX_W-1:0] pick_idx;

  logic signed [DW-1:0] cell_data [CAP];
  logic signed [DW-1:0] cell_pick [CAP];
  logic [CAP-1:0] eq_v, ge_v, live_v;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign exec_fire   = (state_r == S_EXEC) && (!out_valid_r || out_ch.ready);

  // Chain of cells, each tied to its own index and its two neighbors.
  for (genvar k = 0; k < CAP; k++) begin : g_cell
    logic signed [DW-1:0] left_d, right_d;
    if (k == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[k-1];
    end
    if (k == CAP - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[k+1];
    end
    assign live_v[k] = (CNT_W'(k) < cnt_r);

    lst_cell u_cell (
      .clk        (clk),
      .my_idx     (IDX_W'(k)),
      .ctrl       (ctrl),
      .pick_idx   (pick_idx),
      .cmp_val    (val_r),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (cell_data[k]),
      .eq_o       (eq_v[k]),
      .ge_o       (ge_v[k]),
      .pick_o     (cell_pick[k])
    );
  end

  // Priority search for the first live match and the first live entry not below value;
  // OR of the gated cell outputs gives the entry at the delete position.
  logic eq_hit, ge_hit;
  logic [IDX_W-1:0] eq_idx, ge_idx;
  logic signed [DW-1:0] pick_or;

  always_comb begin
    eq_hit  = 1'b0;
    ge_hit  = 1'b0;
    eq_idx  = '0;
    ge_idx  = '0;
    pick_or = '0;
    for (int k = CAP - 1; k >= 0; k--) begin
      if (eq_v[k] && live_v[k]) begin
        eq_hit = 1'b1;
        eq_idx = IDX_W'(k);
      end
      if (ge_v[k] && live_v[k]) begin
        ge_hit = 1'b1;
        ge_idx = IDX_W'(k);
      end
    end
    for (int k = 0; k < CAP; k++) begin
      pick_or = pick_or | cell_pick[k];
    end
  end

  // Operation decode for the execute cycle.
  logic [CMP_W-1:0] pos_ext, cnt_ext, pos_m1, found_wide, len_wide;
  logic             is_full;

  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(cnt_r);
  assign pos_m1  = pos_ext - CMP_W'(1);
  assign pick_idx = pos_m1[IDX_W-1:0];
  assign is_full = (cnt_r == CNT_W'(CAP));
  assign found_wide = CMP_W'(eq_idx) + CMP_W'(1);
  assign len_wide   = CMP_W'(cnt_nxt);

  always_comb begin
    ctrl.shift_up   = 1'b0;
    ctrl.shift_down = 1'b0;
    ctrl.tgt_idx    = pos_m1[IDX_W-1:0];
    ctrl.new_val    = val_r;
    cnt_nxt     = cnt_r;
    status_nxt  = lst_pkg::STAT_OK;
    found_nxt   = '0;
    removed_nxt = '0;
    if (state_r == S_EXEC) begin
      case (op_r)
        lst_pkg::OP_INSERT: begin
          if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
            status_nxt = lst_pkg::STAT_RANGE;
          end else if (is_full) begin
            status_nxt = lst_pkg::STAT_FULL;
          end else begin
            ctrl.shift_up = exec_fire;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        lst_pkg::OP_DELETE: begin
          if (pos_ext == '0 || pos_ext > cnt_ext) begin
            status_nxt = lst_pkg::STAT_RANGE;
          end else begin
            ctrl.shift_down = exec_fire;
            removed_nxt = pick_or;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
        lst_pkg::OP_LOCATE: begin
          if (eq_hit) begin
            found_nxt = found_wide[6:0];
          end else begin
            status_nxt = lst_pkg::STAT_MISSING;
          end
        end
        lst_pkg::OP_SORTED: begin
          if (is_full) begin
            status_nxt = lst_pkg::STAT_FULL;
          end else begin
            ctrl.shift_up = exec_fire;
            ctrl.tgt_idx  = ge_hit ? ge_idx : cnt_r[IDX_W-1:0];
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        lst_pkg::OP_CLEAR: begin
          cnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer state: take a command, then execute it once the result register is free.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_fire) begin
        cnt_r <= cnt_nxt;
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_ch.operation;
      pos_r <= in_ch.position;
      val_r <= in_ch.value;
    end
    if (exec_fire) begin
      status_r  <= status_nxt;
      found_r   <= found_nxt;
      removed_r <= removed_nxt;
      length_r  <= len_wide[6:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.found_position = found_r;
  assign out_ch.removed_value  = removed_r;
  assign out_ch.list_length    = length_r;

  // Checks on the sequencer and the count.
  `LST_ASSERT(a_cnt_bound, cnt_r <= CNT_W'(CAP), "entry count above capacity")
  `LST_ASSERT_NEXT(a_accept_exec, in_fire, state_r == S_EXEC, "accepted beat not executed")
  `LST_ASSERT_NEXT(a_clear_empty, exec_fire && op_r == lst_pkg::OP_CLEAR, cnt_r == '0,
    "clear left entries in the list")
  `LST_ASSERT(a_miss_zero,
    !(out_valid_r && status_r == lst_pkg::STAT_MISSING) || found_r == '0,
    "locate miss with nonzero position")

endmodule

`default_nettype wire

// File: rtl/core/lst_cell.sv
// One cell of the list chain: holds one entry, compares it with the search value
// and takes its neighbor's entry on a shift. Depends on lst_pkg.
`default_nettype none

module lst_cell (
  input  wire logic                            clk,
  input  wire logic [lst_pkg::IDX_W-1:0]       my_idx,
  input  wire lst_pkg::cell_ctrl_t             ctrl,
  input  wire logic [lst_pkg::IDX_W-1:0]       pick_idx,
  input  wire logic signed [lst_pkg::DATA_W-1:0] cmp_val,
  input  wire logic signed [lst_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [lst_pkg::DATA_W-1:0] right_data,
  output logic signed [lst_pkg::DATA_W-1:0]    data_o,
  output logic                                 eq_o,
  output logic                                 ge_o,
  output logic signed [lst_pkg::DATA_W-1:0]    pick_o
);

  logic signed [lst_pkg::DATA_W-1:0] data_r;
  logic signed [lst_pkg::DATA_W-1:0] data_nxt;

  // Entry update: insert moves entries above the target up, delete moves them down.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_up) begin
      if (my_idx == ctrl.tgt_idx) begin
        data_nxt = ctrl.new_val;
      end else if (my_idx > ctrl.tgt_idx) begin
        data_nxt = left_data;
      end
    end else if (ctrl.shift_down) begin
      if (my_idx >= ctrl.tgt_idx) begin
        data_nxt = right_data;
      end
    end
  end

  // Entries are payload and carry no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Compare flags for locate and sorted insert, and the entry read out by delete.
  // The read-out index comes straight from the command register, so it does not
  // depend on the shift control that the decoder derives from these outputs.
  assign eq_o   = (data_r == cmp_val);
  assign ge_o   = !(data_r < cmp_val);
  assign pick_o = (my_idx == pick_idx) ? data_r : '0;
  assign data_o = data_r;

endmodule

`default_nettype wire
